// ----- design/hsfd_pkg.sv -----
// Shared types, constants and helper functions for the humidity sensor frame decoder.
// No dependencies; every other file in the design imports this package.
`timescale 1ns / 1ps

package hsfd_pkg;

    localparam logic [7:0]  CRC_INIT = 8'hFF;
    localparam logic [7:0]  CRC_POLY = 8'h31;

    localparam int TEMP_W = 15;
    localparam int HUM_W  = 14;
    localparam int WORD_W = 16;
    localparam int PROD_W = 31;

    localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd17500;
    localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
    localparam logic signed [WORD_W-1:0] TEMP_OFFSET = 16'sd4500;
    localparam logic [WORD_W-1:0] RAW_FULL    = 16'hFFFF;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] IDX_TEMP_MSB = 3'd0;
    localparam logic [2:0] IDX_TEMP_LSB = 3'd1;
    localparam logic [2:0] IDX_TEMP_CRC = 3'd2;
    localparam logic [2:0] IDX_HUM_MSB  = 3'd3;
    localparam logic [2:0] IDX_HUM_LSB  = 3'd4;
    localparam logic [2:0] IDX_HUM_CRC  = 3'd5;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_first;
    } frame_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_centi;
        logic [HUM_W-1:0]         humidity_centi;
        logic                     crc_ok;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0] temp_word;
        logic [WORD_W-1:0] hum_word;
        logic              ok;
    } frame_rec_t;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^31
    function automatic logic [TEMP_W-1:0] div_full(input logic [PROD_W-1:0] x);
        logic [WORD_W:0]   s;
        logic [TEMP_W-1:0] q;
        s = {2'b00, x[PROD_W-1:WORD_W]} + {1'b0, x[WORD_W-1:0]};
        q = x[PROD_W-1:WORD_W] + ((s >= {1'b0, RAW_FULL}) ? 15'd1 : 15'd0);
        return q;
    endfunction

endpackage

// ----- design/hsfd_front.sv -----
// Front end: accepts frame bytes, assembles the two raw words and checks both CRC-8s.
// Depends on hsfd_pkg; feeds complete frame records to hsfd_fifo.
`timescale 1ns / 1ps

module hsfd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hsfd_pkg::frame_t    frame,
    input  logic                q_full,
    output logic                q_push,
    output hsfd_pkg::frame_rec_t q_rec
);
    import hsfd_pkg::*;

    logic [2:0]        byte_index_reg, byte_index_next;
    logic [7:0]        crc_reg, crc_next;
    logic [WORD_W-1:0] temp_word_reg, temp_word_next;
    logic [WORD_W-1:0] hum_word_reg, hum_word_next;
    logic              temp_good_reg, temp_good_next;
    logic              accept;
    logic [2:0]        idx;
    logic              last_byte;

    assign accept = push && !q_full;
    assign idx    = frame.frame_first ? IDX_TEMP_MSB : byte_index_reg;

    always_comb
    begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        temp_word_next  = temp_word_reg;
        hum_word_next   = hum_word_reg;
        temp_good_next  = temp_good_reg;
        last_byte       = 1'b0;
        if (accept)
        begin
            unique case (idx)
                IDX_TEMP_MSB:
                begin
                    temp_word_next  = {frame.frame_byte, 8'h00};
                    crc_next        = crc_byte(CRC_INIT, frame.frame_byte);
                    byte_index_next = IDX_TEMP_LSB;
                end
                IDX_TEMP_LSB:
                begin
                    temp_word_next  = {temp_word_reg[15:8], frame.frame_byte};
                    crc_next        = crc_byte(crc_reg, frame.frame_byte);
                    byte_index_next = IDX_TEMP_CRC;
                end
                IDX_TEMP_CRC:
                begin
                    temp_good_next  = (crc_reg == frame.frame_byte);
                    crc_next        = CRC_INIT;
                    byte_index_next = IDX_HUM_MSB;
                end
                IDX_HUM_MSB:
                begin
                    hum_word_next   = {frame.frame_byte, 8'h00};
                    crc_next        = crc_byte(CRC_INIT, frame.frame_byte);
                    byte_index_next = IDX_HUM_LSB;
                end
                IDX_HUM_LSB:
                begin
                    hum_word_next   = {hum_word_reg[15:8], frame.frame_byte};
                    crc_next        = crc_byte(crc_reg, frame.frame_byte);
                    byte_index_next = IDX_HUM_CRC;
                end
                default:
                begin
                    crc_next        = CRC_INIT;
                    byte_index_next = IDX_TEMP_MSB;
                    last_byte       = 1'b1;
                end
            endcase
        end
    end

    assign q_push        = last_byte;
    assign q_rec.temp_word = temp_word_reg;
    assign q_rec.hum_word  = hum_word_reg;
    assign q_rec.ok        = temp_good_reg && (crc_reg == frame.frame_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= IDX_TEMP_MSB;
            crc_reg        <= CRC_INIT;
            temp_word_reg  <= '0;
            hum_word_reg   <= '0;
            temp_good_reg  <= 1'b0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            temp_word_reg  <= temp_word_next;
            hum_word_reg   <= hum_word_next;
            temp_good_reg  <= temp_good_next;
        end
    end

endmodule

// ----- design/hsfd_fifo.sv -----
// Short queue of frame records between the front end and the scaling back end.
// Depends on hsfd_pkg for the record type and depth.
`timescale 1ns / 1ps

module hsfd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hsfd_pkg::frame_rec_t wr_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output hsfd_pkg::frame_rec_t rd_rec
);
    import hsfd_pkg::*;

    frame_rec_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_rec  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/hsfd_back.sv -----
// Back end: scales raw words to centi units, keeps the last good values, holds the result.
// Depends on hsfd_pkg; takes frame records from hsfd_fifo.
`timescale 1ns / 1ps

module hsfd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  hsfd_pkg::frame_rec_t q_rec,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output hsfd_pkg::result_t    result
);
    import hsfd_pkg::*;

    logic                     s1_valid_reg;
    logic [PROD_W-1:0]        t_prod_reg;
    logic [PROD_W-2:0]        h_prod_reg;
    logic                     s1_ok_reg;
    logic                     res_valid_reg;
    result_t                  result_reg;
    logic signed [TEMP_W-1:0] last_temp_reg;
    logic [HUM_W-1:0]         last_hum_reg;

    logic                     s2_load, s1_load;
    logic [TEMP_W-1:0]        t_quot, h_quot;
    logic signed [WORD_W-1:0] t_signed;
    logic signed [TEMP_W-1:0] t_new;
    logic [HUM_W-1:0]         h_new;

    assign s2_load = s1_valid_reg && (!res_valid_reg || pop);
    assign s1_load = !s1_valid_reg || s2_load;
    assign q_pop   = s1_load && !q_empty;

    assign t_quot   = div_full(t_prod_reg);
    assign h_quot   = div_full({1'b0, h_prod_reg});
    assign t_signed = signed'({1'b0, t_quot}) - TEMP_OFFSET;
    assign t_new    = t_signed[TEMP_W-1:0];
    assign h_new    = h_quot[HUM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            t_prod_reg <= PROD_W'(q_rec.temp_word) * PROD_W'(TEMP_SCALE);
            h_prod_reg <= (PROD_W-1)'(q_rec.hum_word) * (PROD_W-1)'(HUM_SCALE);
            s1_ok_reg  <= q_rec.ok;
        end
        if (s2_load)
        begin
            result_reg.crc_ok <= s1_ok_reg;
            if (s1_ok_reg)
            begin
                result_reg.temperature_centi <= t_new;
                result_reg.humidity_centi    <= h_new;
            end
            else
            begin
                result_reg.temperature_centi <= last_temp_reg;
                result_reg.humidity_centi    <= last_hum_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            last_temp_reg <= '0;
            last_hum_reg  <= '0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= !q_empty;
            if (s2_load)
                res_valid_reg <= 1'b1;
            else if (pop)
                res_valid_reg <= 1'b0;
            if (s2_load && s1_ok_reg)
            begin
                last_temp_reg <= t_new;
                last_hum_reg  <= h_new;
            end
        end
    end

    assign empty  = !res_valid_reg;
    assign result = result_reg;

endmodule

// ----- design/humidity_sensor_frame_decoder.sv -----
// Top level of the humidity sensor frame decoder: front end, frame queue, back end.
// Depends on hsfd_pkg, hsfd_front, hsfd_fifo and hsfd_back.
`timescale 1ns / 1ps

// Takes one frame byte per cycle while full is low: raw temperature word, its CRC-8, raw
// humidity word, its CRC-8 (polynomial 0x31, init 0xFF, MSB first). The CRC update for
// each byte is done in the cycle that the byte is accepted, so bytes stream at one per
// clock while full is low. After the sixth byte a frame record enters a two-entry queue;
// the scaling back end (one multiply stage, one divide-by-65535 and result stage) passes
// it through both stages in turn. full rises only while the queue holds two frames that
// the back end has not taken. frame_first restarts the byte count and drops any partial
// frame. Failing frames report the last good values with crc_ok low.
module humidity_sensor_frame_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  hsfd_pkg::frame_t  frame,
    output logic              empty,
    input  logic              pop,
    output hsfd_pkg::result_t result
);
    import hsfd_pkg::*;

    logic       q_push, q_full, q_pop, q_empty;
    frame_rec_t wr_rec, rd_rec;

    assign full = q_full;

    hsfd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .frame  (frame),
        .q_full (q_full),
        .q_push (q_push),
        .q_rec  (wr_rec)
    );

    hsfd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_rec (wr_rec),
        .full   (q_full),
        .pop    (q_pop),
        .empty  (q_empty),
        .rd_rec (rd_rec)
    );

    hsfd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rec   (rd_rec),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ----- design/hsfd_checker.sv -----
// Port-level checks for the humidity sensor frame decoder, bound to the top level.
// Depends on hsfd_pkg and humidity_sensor_frame_decoder.
`timescale 1ns / 1ps

module hsfd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input hsfd_pkg::result_t result
);
    import hsfd_pkg::*;

    // hold a waiting result until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed or vanished before pop");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.humidity_centi <= 14'd10000)
        else $error("humidity out of range");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.temperature_centi >= -15'sd4500)
                && (result.temperature_centi <= 15'sd13000))
        else $error("temperature out of range");

    a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("full or empty unknown");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for humidity_sensor_frame_decoder: streams sensor frame bytes
// through the request queue and checks every decoded reading against a built-in predictor.
// Depends on hsfd_pkg and the design top level only.
`timescale 1ns / 1ps

module tb_top;
    import hsfd_pkg::*;

    localparam int unsigned TEMP_SPAN  = 17500;
    localparam int unsigned HUM_SPAN   = 10000;
    localparam int unsigned RAW_SPAN   = 65535;
    localparam int          TEMP_BASE  = 4500;
    localparam logic [2:0]  POS_HUM_CRC = 3'd5;
    localparam int          STALL_LIMIT = 5000;
    localparam int          ITEMS_PER_PHASE = 500;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    logic    full;
    logic    empty;
    frame_t  frame = '0;
    result_t result;

    humidity_sensor_frame_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .frame  (frame),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    frame_t      pending_bytes[$];
    result_t     expected_readings[$];
    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          idle_cycles = 0;

    logic [2:0]               byte_pos = IDX_TEMP_MSB;
    logic [7:0]               crc_acc = CRC_INIT;
    logic [15:0]              t_word = '0;
    logic [15:0]              h_word = '0;
    logic                     t_crc_ok = 1'b0;
    logic signed [TEMP_W-1:0] held_temp = '0;
    logic [HUM_W-1:0]         held_hum = '0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        repeat (8)
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        return c;
    endfunction

    task automatic decode_byte(input frame_t f);
        result_t     r;
        logic        good;
        int unsigned scaled;
        if (f.frame_first)
            byte_pos = IDX_TEMP_MSB;
        case (byte_pos)
            IDX_TEMP_MSB:
            begin
                t_word = {f.frame_byte, 8'h00};
                crc_acc = crc8_step(CRC_INIT, f.frame_byte);
                byte_pos = IDX_TEMP_LSB;
            end
            IDX_TEMP_LSB:
            begin
                t_word[7:0] = f.frame_byte;
                crc_acc = crc8_step(crc_acc, f.frame_byte);
                byte_pos = IDX_TEMP_CRC;
            end
            IDX_TEMP_CRC:
            begin
                t_crc_ok = (crc_acc == f.frame_byte);
                crc_acc = CRC_INIT;
                byte_pos = IDX_HUM_MSB;
            end
            IDX_HUM_MSB:
            begin
                h_word = {f.frame_byte, 8'h00};
                crc_acc = crc8_step(CRC_INIT, f.frame_byte);
                byte_pos = IDX_HUM_LSB;
            end
            IDX_HUM_LSB:
            begin
                h_word[7:0] = f.frame_byte;
                crc_acc = crc8_step(crc_acc, f.frame_byte);
                byte_pos = POS_HUM_CRC;
            end
            default:
            begin
                good = t_crc_ok && (crc_acc == f.frame_byte);
                if (good)
                begin
                    scaled = (t_word * TEMP_SPAN) / RAW_SPAN;
                    held_temp = TEMP_W'(int'(scaled) - TEMP_BASE);
                    scaled = (h_word * HUM_SPAN) / RAW_SPAN;
                    held_hum = HUM_W'(scaled);
                end
                crc_acc = CRC_INIT;
                byte_pos = IDX_TEMP_MSB;
                r.temperature_centi = held_temp;
                r.humidity_centi = held_hum;
                r.crc_ok = good;
                expected_readings.push_back(r);
            end
        endcase
    endtask

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic first);
        frame_t f;
        f.frame_byte = b;
        f.frame_first = first;
        pending_bytes.push_back(f);
        n_queued++;
    endtask

    task automatic queue_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                               input logic bad_t, input logic bad_h, input logic mark);
        logic [7:0] crc_t;
        logic [7:0] crc_h;
        crc_t = crc8_step(crc8_step(CRC_INIT, raw_t[15:8]), raw_t[7:0]);
        crc_h = crc8_step(crc8_step(CRC_INIT, raw_h[15:8]), raw_h[7:0]);
        if (bad_t)
            crc_t ^= 8'($urandom_range(255, 1));
        if (bad_h)
            crc_h ^= 8'($urandom_range(255, 1));
        queue_byte(raw_t[15:8], mark);
        queue_byte(raw_t[7:0], 1'b0);
        queue_byte(crc_t, 1'b0);
        queue_byte(raw_h[15:8], 1'b0);
        queue_byte(raw_h[7:0], 1'b0);
        queue_byte(crc_h, 1'b0);
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic queue_random(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        start = n_queued;
        while (n_queued - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                queue_frame(pick_raw(), pick_raw(), $urandom_range(9) == 0,
                            $urandom_range(9) == 0, $urandom_range(4) != 0);
            else if (pick < 90)
            begin
                len = $urandom_range(5, 1);
                for (int i = 0; i < len; i++)
                    queue_byte(8'($urandom_range(255)), i == 0);
            end
            else
            begin
                len = $urandom_range(4, 1);
                repeat (len)
                    queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_readings.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                decode_byte(frame);
                n_accepted++;
            end
            if (!push || !full)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    frame <= pending_bytes.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_readings.size() == 0)
                    report_error("reading with no request pending");
                else
                begin
                    check_field("temperature_centi", 16'(result.temperature_centi),
                                16'(expected_readings[0].temperature_centi));
                    check_field("humidity_centi", 16'(result.humidity_centi),
                                16'(expected_readings[0].humidity_centi));
                    check_field("crc_ok", 16'(result.crc_ok),
                                16'(expected_readings[0].crc_ok));
                    void'(expected_readings.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
        queue_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h12, 1'b1);
        queue_byte(8'h34, 1'b0);
        queue_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        queue_frame(16'h1234, 16'h5678, 1'b0, 1'b1, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            queue_random(ITEMS_PER_PHASE);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
design/hsfd_pkg.sv
design/hsfd_front.sv
design/hsfd_fifo.sv
design/hsfd_back.sv
design/humidity_sensor_frame_decoder.sv
design/hsfd_checker.sv
sim/tb_top.sv
